// File: rtl/core/assert_macros.svh
// Assertion helpers for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define GBF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define GBF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/core/gbf_pkg.sv
`default_nettype none
package gbf_pkg;
   localparam int MaxNodes  = 64;
   localparam int MaxEdges  = 256;
   localparam int NodeW     = $clog2(MaxNodes);
   localparam int EdgeW     = $clog2(MaxEdges);
   localparam int CountW    = EdgeW + 1;
   localparam int TimeW     = 7;
   localparam int DepthW    = NodeW + 1;
   localparam logic [TimeW-1:0] NoParent = '1;

   typedef enum logic {
      CMD_APPEND = 1'b0,
      CMD_RUN    = 1'b1
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_ROOT,
      ST_ROOT_CHK,
      ST_EDGE,
      ST_EDGE_CHK,
      ST_NEIGH,
      ST_PUSH,
      ST_POP,
      ST_POP_PAR,
      ST_EMIT,
      ST_END
   } state_type;

   typedef struct packed {
      logic [NodeW-1:0] parent;
      logic [NodeW-1:0] child;
      logic             is_bridge;
      logic             last;
      logic             dropped;
   } result_type;
endpackage
`default_nettype wire

// File: rtl/core/graph_bridge_finder_top.sv
`default_nettype none
`include "assert_macros.svh"
// Bridge finder. An append item (cmd 0) stores one edge, or sets the dropped
// flag if the store is full or a node id is not below the count, and is taken
// once per cycle while idle with the result register empty; it gives no result.
// A run item (cmd 1) clears the visit times of all 64 nodes, checks each root
// below the node count and walks the graph depth first with an explicit stack.
// Each visited node scans every stored edge, looks up each neighbor and pushes
// each unvisited child; closing a node pops it and, when it has a parent, hands
// its low link back. The run returns one item per bridge, up to 63, then an end
// marker with tlast set, and stalls while the result register waits on
// rsp_tready. Input is held off from the run item until the end marker has
// left.
module graph_bridge_finder_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [6:0]  csr_wr_data,   // node_count
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,     // cmd, node_a, node_b, zero fill
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,     // bridge_parent, bridge_child,
                                           // is_bridge, edges_dropped, fill
   output logic             rsp_tlast      // last
);
   localparam int NodeW  = gbf_pkg::NodeW;
   localparam int TimeW  = gbf_pkg::TimeW;
   localparam int CountW = gbf_pkg::CountW;
   localparam int DepthW = gbf_pkg::DepthW;
   localparam int EdgeW  = gbf_pkg::EdgeW;

   gbf_pkg::state_type state_ff, state_in;
   logic [6:0]        count_ff, count_in;
   logic [CountW-1:0] total_ff, total_in;
   logic              drop_ff, drop_in;
   logic [TimeW-1:0]  clk_ff, clk_in;
   logic [DepthW-1:0] depth_ff, depth_in;
   logic [DepthW-1:0] root_ff, root_in;
   logic [NodeW-1:0]  u_ff, u_in;
   logic [TimeW-1:0]  upar_ff, upar_in;
   logic [CountW-1:0] pos_ff, pos_in;
   logic [TimeW-1:0]  ulow_ff, ulow_in;
   logic [TimeW-1:0]  udisc_ff, udisc_in;
   logic [NodeW-1:0]  v_ff, v_in;
   logic [5:0]        nres_ff, nres_in;
   gbf_pkg::result_type out_ff, out_in;
   logic              ovalid_ff, ovalid_in;

   // memory ports
   logic              e_we;
   logic [EdgeW-1:0]  e_waddr, e_raddr;
   logic [NodeW-1:0]  e_ra, e_rb;
   logic              n_we;
   logic [NodeW-1:0]  n_waddr, n_raddr;
   logic [TimeW-1:0]  n_wdisc, n_wlow, n_rdisc, n_rlow;
   logic              s_we;
   logic [NodeW-1:0]  s_waddr, s_raddr, s_rnode;
   logic [TimeW-1:0]  s_wpar, s_rpar;
   logic [CountW-1:0] s_wpos, s_rpos;
   logic [NodeW-1:0]  s_wnode;

   logic [6:0]        eff_n;
   logic              req_acc;
   logic              cmd;
   logic [NodeW-1:0]  in_a, in_b;
   logic [TimeW-1:0]  clk_next;
   logic              hit_a, hit_b;
   logic [NodeW-1:0]  nb;
   logic              nb_skip;
   logic              out_free;
   logic              is_br;

   gbf_edge_store u_edges (
      .clock(clock), .wr_en(e_we), .wr_addr(e_waddr), .wr_a(in_a), .wr_b(in_b),
      .rd_addr(e_raddr), .rd_a(e_ra), .rd_b(e_rb));

   gbf_node_store u_nodes (
      .clock(clock), .wr_en(n_we), .wr_addr(n_waddr), .wr_disc(n_wdisc),
      .wr_low(n_wlow), .rd_addr(n_raddr), .rd_disc(n_rdisc), .rd_low(n_rlow));

   gbf_stack u_stack (
      .clock(clock), .wr_en(s_we), .wr_addr(s_waddr), .wr_node(s_wnode),
      .wr_parent(s_wpar), .wr_pos(s_wpos), .rd_addr(s_raddr),
      .rd_node(s_rnode), .rd_parent(s_rpar), .rd_pos(s_rpos));

   assign cmd     = req_tdata[0];
   assign in_a    = req_tdata[NodeW:1];
   assign in_b    = req_tdata[2*NodeW:NodeW+1];
   assign eff_n   = (count_ff > 7'(gbf_pkg::MaxNodes)) ? 7'(gbf_pkg::MaxNodes) : count_ff;
   assign req_tready = (state_ff == gbf_pkg::ST_IDLE) && !ovalid_ff;
   assign req_acc = req_tvalid && req_tready;
   assign clk_next = clk_ff + TimeW'(1);

   // neighbor of the top node on the edge just read
   assign hit_a   = (e_ra == u_ff);
   assign hit_b   = (e_rb == u_ff);
   assign nb      = hit_a ? e_rb : e_ra;
   assign nb_skip = !(hit_a || hit_b) || ({1'b0, nb} == upar_ff);

   assign out_free = !ovalid_ff || rsp_tready;
   // parent in u_ff, child low still in ulow_ff
   assign is_br    = (n_rdisc < ulow_ff) && (nres_ff != 6'd63);

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tlast  = out_ff.last;
   assign rsp_tdata  = {2'b00, out_ff.dropped, out_ff.is_bridge, out_ff.child, out_ff.parent};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gbf_pkg::ST_IDLE:
            if (req_acc && cmd == gbf_pkg::CMD_RUN) state_in = gbf_pkg::ST_CLEAR;
         gbf_pkg::ST_CLEAR:
            if (root_ff == DepthW'(gbf_pkg::MaxNodes - 1)) state_in = gbf_pkg::ST_ROOT;
         gbf_pkg::ST_ROOT:
            if (root_ff >= DepthW'(eff_n)) state_in = gbf_pkg::ST_END;
            else state_in = gbf_pkg::ST_ROOT_CHK;
         gbf_pkg::ST_ROOT_CHK:
            if (n_rdisc != '0) state_in = gbf_pkg::ST_ROOT;
            else state_in = gbf_pkg::ST_EDGE;
         gbf_pkg::ST_EDGE:
            if (pos_ff < total_ff) state_in = gbf_pkg::ST_EDGE_CHK;
            else state_in = gbf_pkg::ST_POP;
         gbf_pkg::ST_EDGE_CHK:
            if (nb_skip) state_in = gbf_pkg::ST_EDGE;
            else state_in = gbf_pkg::ST_NEIGH;
         gbf_pkg::ST_NEIGH:
            if (n_rdisc == '0) state_in = gbf_pkg::ST_PUSH;
            else state_in = gbf_pkg::ST_EDGE;
         gbf_pkg::ST_PUSH: state_in = gbf_pkg::ST_EDGE;
         gbf_pkg::ST_POP:
            if (depth_ff == DepthW'(1)) state_in = gbf_pkg::ST_ROOT;
            else state_in = gbf_pkg::ST_POP_PAR;
         gbf_pkg::ST_POP_PAR: state_in = gbf_pkg::ST_EMIT;
         gbf_pkg::ST_EMIT:
            if (!is_br || out_free) state_in = gbf_pkg::ST_EDGE;
         gbf_pkg::ST_END:
            if (out_free) state_in = gbf_pkg::ST_IDLE;
         default: state_in = gbf_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      count_in  = csr_wr_en ? csr_wr_data : count_ff;
      total_in  = total_ff;
      drop_in   = drop_ff;
      clk_in    = clk_ff;
      depth_in  = depth_ff;
      root_in   = root_ff;
      u_in      = u_ff;
      upar_in   = upar_ff;
      pos_in    = pos_ff;
      ulow_in   = ulow_ff;
      udisc_in  = udisc_ff;
      v_in      = v_ff;
      nres_in   = nres_ff;
      out_in    = out_ff;
      ovalid_in = ovalid_ff && !rsp_tready;
      e_we = 1'b0; e_waddr = total_ff[EdgeW-1:0]; e_raddr = pos_ff[EdgeW-1:0];
      n_we = 1'b0; n_waddr = root_ff[NodeW-1:0];
      n_wdisc = '0; n_wlow = '0; n_raddr = root_ff[NodeW-1:0];
      s_we = 1'b0; s_waddr = depth_ff[NodeW-1:0]; s_wnode = u_ff;
      s_wpar = upar_ff; s_wpos = pos_ff; s_raddr = depth_ff[NodeW-1:0];
      unique case (state_ff)
         gbf_pkg::ST_IDLE:
            if (req_acc) begin
               if (cmd == gbf_pkg::CMD_APPEND) begin
                  if (total_ff >= CountW'(gbf_pkg::MaxEdges)
                      || {1'b0, in_a} >= eff_n || {1'b0, in_b} >= eff_n) begin
                     drop_in = 1'b1;
                  end else begin
                     e_we = 1'b1;
                     total_in = total_ff + CountW'(1);
                  end
               end else begin
                  root_in = '0; clk_in = '0; depth_in = '0; nres_in = '0;
               end
            end
         gbf_pkg::ST_CLEAR: begin
            // clear every node: stored edges may reach ids above the count
            n_we = 1'b1;
            if (root_ff == DepthW'(gbf_pkg::MaxNodes - 1)) root_in = '0;
            else root_in = root_ff + DepthW'(1);
         end
         gbf_pkg::ST_ROOT: ;
         gbf_pkg::ST_ROOT_CHK:
            if (n_rdisc != '0) begin
               root_in = root_ff + DepthW'(1);
            end else begin
               clk_in = clk_next;
               n_we = 1'b1;
               n_wdisc = clk_next;
               n_wlow = clk_next;
               u_in = root_ff[NodeW-1:0];
               upar_in = gbf_pkg::NoParent;
               pos_in = '0;
               ulow_in = clk_next;
               udisc_in = clk_next;
               depth_in = DepthW'(1);
            end
         gbf_pkg::ST_EDGE: ;
         gbf_pkg::ST_EDGE_CHK: begin
            pos_in = pos_ff + CountW'(1);
            v_in = nb;
            n_raddr = nb;
         end
         gbf_pkg::ST_NEIGH:
            if (n_rdisc == '0) begin
               // stamp the new node now, switch to it on the next cycle
               clk_in = clk_next;
               n_we = 1'b1;
               n_waddr = v_ff;
               n_wdisc = clk_next;
               n_wlow = clk_next;
            end else if (n_rdisc < ulow_ff) begin
               ulow_in = n_rdisc;
            end
         gbf_pkg::ST_PUSH: begin
            // save the current top frame and its low link
            s_we = 1'b1;
            s_waddr = NodeW'(depth_ff - DepthW'(1));
            n_we = 1'b1;
            n_waddr = u_ff;
            n_wdisc = udisc_ff;
            n_wlow = ulow_ff;
            u_in = v_ff;
            upar_in = {1'b0, u_ff};
            pos_in = '0;
            ulow_in = clk_ff;
            udisc_in = clk_ff;
            depth_in = depth_ff + DepthW'(1);
         end
         gbf_pkg::ST_POP: begin
            depth_in = depth_ff - DepthW'(1);
            if (depth_ff == DepthW'(1)) root_in = root_ff + DepthW'(1);
            else s_raddr = NodeW'(depth_ff - DepthW'(2));
         end
         gbf_pkg::ST_POP_PAR: begin
            v_in = u_ff;
            u_in = s_rnode;
            upar_in = s_rpar;
            pos_in = s_rpos;
            n_raddr = s_rnode;
         end
         gbf_pkg::ST_EMIT: begin
            n_raddr = u_ff;
            if (!is_br || out_free) begin
               udisc_in = n_rdisc;
               ulow_in = (ulow_ff < n_rlow) ? ulow_ff : n_rlow;
               if (is_br) begin
                  out_in = '{parent: u_ff, child: v_ff, is_bridge: 1'b1, last: 1'b0,
                             dropped: drop_ff};
                  ovalid_in = 1'b1;
                  nres_in = nres_ff + 6'd1;
               end
            end
         end
         gbf_pkg::ST_END:
            if (out_free) begin
               out_in = '{parent: '0, child: '0, is_bridge: 1'b0, last: 1'b1,
                          dropped: drop_ff};
               ovalid_in = 1'b1;
               total_in = '0;
               drop_in = 1'b0;
            end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= gbf_pkg::ST_IDLE;
         count_ff  <= 7'd64;
         total_ff  <= '0;
         drop_ff   <= 1'b0;
         ovalid_ff <= 1'b0;
         depth_ff  <= '0;
         clk_ff    <= '0;
         root_ff   <= '0;
         nres_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         total_ff  <= total_in;
         drop_ff   <= drop_in;
         ovalid_ff <= ovalid_in;
         depth_ff  <= depth_in;
         clk_ff    <= clk_in;
         root_ff   <= root_in;
         nres_ff   <= nres_in;
      end
      u_ff     <= u_in;
      upar_ff  <= upar_in;
      pos_ff   <= pos_in;
      ulow_ff  <= ulow_in;
      udisc_ff <= udisc_in;
      v_ff     <= v_in;
      out_ff   <= out_in;
   end

   `GBF_ASSERT(a_no_accept_busy, clock, reset,
      req_acc |-> state_ff == gbf_pkg::ST_IDLE, "item taken while busy")
   `GBF_ASSERT(a_total_bound, clock, reset,
      total_ff <= CountW'(gbf_pkg::MaxEdges), "edge count overflow")
   `GBF_ASSERT(a_depth_bound, clock, reset,
      depth_ff <= DepthW'(gbf_pkg::MaxNodes), "stack overflow")
endmodule
`default_nettype wire

// File: rtl/core/gbf_edge_store.sv
`default_nettype none
module gbf_edge_store (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [gbf_pkg::EdgeW-1:0] wr_addr,
   input  wire logic [gbf_pkg::NodeW-1:0] wr_a,
   input  wire logic [gbf_pkg::NodeW-1:0] wr_b,
   input  wire logic [gbf_pkg::EdgeW-1:0] rd_addr,
   output logic      [gbf_pkg::NodeW-1:0] rd_a,
   output logic      [gbf_pkg::NodeW-1:0] rd_b
);
   logic [2*gbf_pkg::NodeW-1:0] mem [gbf_pkg::MaxEdges];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_b, wr_a};
      end
      {rd_b, rd_a} <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: rtl/core/gbf_node_store.sv
`default_nettype none
// Per-node visit time and low link, one word per node.
module gbf_node_store (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [gbf_pkg::NodeW-1:0] wr_addr,
   input  wire logic [gbf_pkg::TimeW-1:0] wr_disc,
   input  wire logic [gbf_pkg::TimeW-1:0] wr_low,
   input  wire logic [gbf_pkg::NodeW-1:0] rd_addr,
   output logic      [gbf_pkg::TimeW-1:0] rd_disc,
   output logic      [gbf_pkg::TimeW-1:0] rd_low
);
   logic [2*gbf_pkg::TimeW-1:0] mem [gbf_pkg::MaxNodes];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_low, wr_disc};
      end
      {rd_low, rd_disc} <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: rtl/core/gbf_stack.sv
`default_nettype none
// Search stack: node, tree parent and scan position per level.
module gbf_stack (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [gbf_pkg::NodeW-1:0]  wr_addr,
   input  wire logic [gbf_pkg::NodeW-1:0]  wr_node,
   input  wire logic [gbf_pkg::TimeW-1:0]  wr_parent,
   input  wire logic [gbf_pkg::CountW-1:0] wr_pos,
   input  wire logic [gbf_pkg::NodeW-1:0]  rd_addr,
   output logic      [gbf_pkg::NodeW-1:0]  rd_node,
   output logic      [gbf_pkg::TimeW-1:0]  rd_parent,
   output logic      [gbf_pkg::CountW-1:0] rd_pos
);
   localparam int W = gbf_pkg::NodeW + gbf_pkg::TimeW + gbf_pkg::CountW;
   logic [W-1:0] mem [gbf_pkg::MaxNodes];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_pos, wr_parent, wr_node};
      end
      {rd_pos, rd_parent, rd_node} <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: tb/testbench.sv
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WatchdogLimit = 200000;
   localparam int NoRoot = 127;

   // predicts bridge items from the appended edges and checks the responses
   class bridge_scoreboard;
      bit [5:0]   edge_a[gbf_pkg::MaxEdges];
      bit [5:0]   edge_b[gbf_pkg::MaxEdges];
      int         edge_count;
      bit         dropped;
      bit [6:0]   node_limit;
      int         disc[gbf_pkg::MaxNodes];
      int         low[gbf_pkg::MaxNodes];
      int         stk_node[gbf_pkg::MaxNodes];
      int         stk_par[gbf_pkg::MaxNodes];
      int         stk_pos[gbf_pkg::MaxNodes];
      gbf_pkg::result_type pending_q[$];
      int         errors;
      int         runs;
      int         bridges;

      function new();
         node_limit = 7'd64;
      endfunction

      function int live_nodes();
         return (node_limit > gbf_pkg::MaxNodes) ? gbf_pkg::MaxNodes : int'(node_limit);
      endfunction

      function void set_limit(bit [6:0] value);
         node_limit = value;
      endfunction

      function void push_result(int par, int chi, bit isb, bit lst);
         gbf_pkg::result_type r;
         r.parent    = par[gbf_pkg::NodeW-1:0];
         r.child     = chi[gbf_pkg::NodeW-1:0];
         r.is_bridge = isb;
         r.last      = lst;
         r.dropped   = dropped;
         pending_q = {pending_q, r};
      endfunction

      function void note_item(gbf_pkg::cmd_type cmd, bit [5:0] a, bit [5:0] b);
         int n, depth, clk_n, found, top, u, v, i, p;
         n = live_nodes();
         if (cmd == gbf_pkg::CMD_APPEND) begin
            if (edge_count >= gbf_pkg::MaxEdges || a >= n || b >= n) begin
               dropped = 1'b1;
            end else begin
               edge_a[edge_count] = a;
               edge_b[edge_count] = b;
               edge_count++;
            end
            return;
         end
         runs++;
         foreach (disc[j]) disc[j] = 0;
         clk_n = 0;
         depth = 0;
         found = 0;
         for (int r = 0; r < n; r++) begin
            if (disc[r] != 0) continue;
            clk_n++;
            disc[r] = clk_n;
            low[r] = clk_n;
            stk_node[0] = r;
            stk_par[0] = NoRoot;
            stk_pos[0] = 0;
            depth = 1;
            while (depth > 0) begin
               top = depth - 1;
               u = stk_node[top];
               if (stk_pos[top] < edge_count) begin
                  i = stk_pos[top];
                  stk_pos[top]++;
                  if (edge_a[i] == u) v = edge_b[i];
                  else if (edge_b[i] == u) v = edge_a[i];
                  else continue;
                  // every edge back to the tree parent is skipped, parallel ones too
                  if (v == stk_par[top]) continue;
                  if (disc[v] == 0) begin
                     clk_n++;
                     disc[v] = clk_n;
                     low[v] = clk_n;
                     stk_node[depth] = v;
                     stk_par[depth] = u;
                     stk_pos[depth] = 0;
                     depth++;
                  end else if (disc[v] < low[u]) begin
                     low[u] = disc[v];
                  end
               end else begin
                  depth--;
                  if (depth > 0) begin
                     p = stk_node[depth - 1];
                     if (low[u] < low[p]) low[p] = low[u];
                     if (disc[p] < low[u] && found < 63) begin
                        push_result(p, u, 1'b1, 1'b0);
                        found++;
                     end
                  end
               end
            end
         end
         bridges += found;
         push_result(0, 0, 1'b0, 1'b1);
         edge_count = 0;
         dropped = 1'b0;
      endfunction

      task report(string what, int got, int want);
         $display("mismatch %0t: %s got %0d expected %0d", $realtime, what, got, want);
         errors++;
      endtask

      task check_result(logic [15:0] data, logic lst);
         gbf_pkg::result_type w;
         if (pending_q.size() == 0) begin
            report("unexpected item, tdata", int'(data), -1);
            return;
         end
         w = pending_q.pop_front();
         if (data[5:0] !== w.parent)
            report("bridge_parent", int'(data[5:0]), int'(w.parent));
         if (data[11:6] !== w.child)
            report("bridge_child", int'(data[11:6]), int'(w.child));
         if (data[12] !== w.is_bridge)
            report("is_bridge", int'(data[12]), int'(w.is_bridge));
         if (data[13] !== w.dropped)
            report("edges_dropped", int'(data[13]), int'(w.dropped));
         if (lst !== w.last) report("last", int'(lst), int'(w.last));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [6:0]  csr_wr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;    // cmd, node_a, node_b, zero fill
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;    // bridge_parent, bridge_child, is_bridge, edges_dropped, fill
   logic        rsp_tlast;    // last

   bridge_scoreboard sb = new();
   bit tx_idle, rx_idle;
   int rx_gap, hold_left, hold_req;
   int stall_cycles, items_sent;

   graph_bridge_finder_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side: random stalls, plus a long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_gap = 0;
         hold_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tdata, rsp_tlast);
            rx_gap = rx_idle ? $urandom_range(0, 15) : 0;
         end
         if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rx_gap > 0) begin
            rx_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WatchdogLimit) begin
         $display("watchdog: no item moved for %0d cycles", stall_cycles);
         $display("testbench: errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_item(gbf_pkg::cmd_type cmd, bit [5:0] a, bit [5:0] b);
      int gap;
      gap = tx_idle ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, b, a, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_item(cmd, a, b);
      items_sent++;
   endtask

   task automatic append_edge(int a, int b);
      send_item(gbf_pkg::CMD_APPEND, a[5:0], b[5:0]);
   endtask

   task automatic run_search();
      send_item(gbf_pkg::CMD_RUN, 6'($urandom), 6'($urandom));
   endtask

   // drain all responses, let trailing appends settle, then write the register
   task automatic set_node_count(int value);
      req_tvalid <= 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value[6:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_limit(value[6:0]);
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
   endtask

   // random graph: mostly local edges so cycles and bridges both occur
   task automatic random_graph(int cnt, int n_edges);
      int a, b, span;
      span = (cnt > 1) ? cnt : 1;
      for (int i = 0; i < n_edges; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            a = $urandom_range(0, 63);
            b = $urandom_range(0, 63);
         end else begin
            a = $urandom_range(0, span - 1);
            b = ($urandom_range(0, 4) == 0) ? $urandom_range(0, span - 1)
                                            : (a + $urandom_range(0, 2)) % span;
         end
         append_edge(a, b);
      end
   endtask

   initial begin
      int cnt;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      hold_req = 0;
      items_sent = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // bridges at the root, a cycle, self loop, doubled edge, top ids
      append_edge(0, 1);
      append_edge(1, 2);
      append_edge(2, 3);
      append_edge(3, 1);
      append_edge(4, 4);
      append_edge(5, 6);
      append_edge(6, 5);
      append_edge(63, 62);
      append_edge(0, 63);
      run_search();
      set_node_count(4);
      append_edge(0, 1);
      append_edge(5, 2);
      append_edge(3, 63);
      run_search();
      set_node_count(0);
      append_edge(0, 0);
      run_search();
      // lower the count after loading: high nodes are reached, never roots
      set_node_count(64);
      append_edge(10, 11);
      append_edge(11, 40);
      append_edge(40, 41);
      set_node_count(20);
      run_search();
      set_node_count(127);
      append_edge(42, 21);
      run_search();

      // long chain while the result side holds off; appends pile up behind the run
      set_node_count(40);
      for (int i = 0; i < 39; i++) append_edge(i, i + 1);
      hold_req = 4000;
      run_search();
      random_graph(40, 6);
      run_search();

      // fill the edge store past its end
      set_node_count(3);
      for (int i = 0; i < gbf_pkg::MaxEdges + 2; i++) append_edge(i % 3, (i + 1) % 3);
      run_search();

      while (items_sent < 380) begin
         case ($urandom_range(0, 3))
            0: cnt = 1;
            1: cnt = 64;
            default: cnt = $urandom_range(2, 24);
         endcase
         set_node_count(cnt);
         random_graph(cnt, $urandom_range(0, 24));
         run_search();
      end

      req_tvalid <= 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("covered %0d items, %0d searches, %0d bridges found",
               items_sent, sb.runs, sb.bridges);
      $display("node counts from 0 to 127, a full edge store and a long result stall");
      if (sb.errors == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end
endmodule
`default_nettype wire
